// ----- hw/rtl/kps_pkg.sv -----
// Package for the keypad scanner: configuration defaults, register indexes
// and the result word type shared by the scan core and the top level.
// Depends on nothing.
`default_nettype none

package kps_pkg;

	localparam int unsigned COLUMNS_DEF = 3;
	localparam int unsigned ROWS_DEF    = 4;

	localparam int unsigned ROW_W   = 4;
	localparam int unsigned DRIVE_W = 3;
	localparam int unsigned CODE_W  = 6;
	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned DWELL_W = 10;
	localparam int unsigned CFG_W   = 16;

	localparam logic [15:0] HOLD_RESET  = 16'd1500;
	localparam logic [9:0]  DWELL_RESET = 10'd30;

	localparam logic CFG_HOLD  = 1'b0;
	localparam logic CFG_DWELL = 1'b1;

	typedef struct packed {
		logic [DRIVE_W-1:0] column_drive;
		logic               event_valid;
		logic               event_kind;
		logic [CODE_W-1:0]  button_code;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kps_if.sv -----
// Handshake channels of the keypad scanner: the row sample word in and the
// scan result word out. Depends on kps_pkg for the field widths.
`default_nettype none

interface kps_row_if;
	logic                         valid;
	logic                         ready;
	logic [kps_pkg::ROW_W-1:0]    row_lines;

	modport source (output valid, output row_lines, input ready);
	modport sink (input valid, input row_lines, output ready);
endinterface

interface kps_event_if;
	logic                         valid;
	logic                         ready;
	logic [kps_pkg::DRIVE_W-1:0]  column_drive;
	logic                         event_valid;
	logic                         event_kind;
	logic [kps_pkg::CODE_W-1:0]   button_code;

	modport source (output valid, output column_drive, output event_valid,
		output event_kind, output button_code, input ready);
	modport sink (input valid, input column_drive, input event_valid,
		input event_kind, input button_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kps_scan.sv -----
// Scan state machine: column, row and phase registers, the press timer and
// the event decision for one row sample word. Depends on kps_pkg.
`default_nettype none

module kps_scan #(
	parameter int unsigned COLUMNS = kps_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = kps_pkg::ROWS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [kps_pkg::ROW_W-1:0]     rows,
	input  wire logic [kps_pkg::HOLD_W-1:0]    hold_ticks,
	input  wire logic [kps_pkg::DWELL_W-1:0]   dwell_ticks,
	output kps_pkg::result_t                   result
);
	import kps_pkg::*;

	localparam logic [1:0] PH_SCANNING  = 2'd0;
	localparam logic [1:0] PH_TIMING    = 2'd1;
	localparam logic [1:0] PH_RELEASING = 2'd2;
	localparam logic [1:0] PH_DWELL     = 2'd3;

	localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((5'd1 << ROWS) - 5'd1);
	localparam logic [2:0]       COL_LIM  = 3'(COLUMNS);

	logic [1:0]        column_q, column_d;
	logic [2:0]        next_row_q, next_row_d;
	logic [1:0]        active_row_q, active_row_d;
	logic [1:0]        phase_q, phase_d;
	logic [HOLD_W-1:0] tick_q, tick_d;

	logic [ROW_W-1:0]  rows_m;
	logic [HOLD_W-1:0] tick_inc;
	logic              found;
	logic [1:0]        hit_row;
	logic [2:0]        column_inc;
	logic              row_down;

	always_comb begin
		rows_m   = rows & ROW_MASK;
		tick_inc = (tick_q == '1) ? tick_q : tick_q + HOLD_W'(1);
		row_down = rows_m[active_row_q];
		column_inc = {1'b0, column_q} + 3'd1;
		found   = 1'b0;
		hit_row = 2'd0;
		for (int r = ROW_W - 1; r >= 0; r--) begin
			if (rows_m[r] && (3'(r) >= next_row_q)) begin
				found   = 1'b1;
				hit_row = 2'(r);
			end
		end
	end

	always_comb begin
		column_d     = column_q;
		next_row_d   = next_row_q;
		active_row_d = active_row_q;
		phase_d      = phase_q;
		tick_d       = tick_q;
		result.column_drive = DRIVE_W'(4'b0001 << column_q);
		result.event_valid  = 1'b0;
		result.event_kind   = 1'b0;
		result.button_code  = '0;
		unique case (phase_q)
			PH_SCANNING: begin
				tick_d = '0;
				if (found) begin
					active_row_d = hit_row;
					next_row_d   = {1'b0, hit_row} + 3'd1;
					phase_d      = PH_TIMING;
				end else begin
					column_d   = (column_inc >= COL_LIM) ? 2'd0 : column_inc[1:0];
					next_row_d = '0;
					phase_d    = PH_DWELL;
				end
			end
			PH_TIMING: begin
				tick_d = tick_inc;
				if (tick_inc >= hold_ticks) begin
					result.event_valid = 1'b1;
					result.event_kind  = 1'b1;
				end else if (!row_down) begin
					result.event_valid = 1'b1;
				end
				if (result.event_valid) begin
					result.button_code = (CODE_W'(column_q) << ROWS) |
						CODE_W'(active_row_q);
					phase_d = PH_RELEASING;
				end
			end
			PH_RELEASING: begin
				if (!row_down) begin
					phase_d = PH_SCANNING;
				end
			end
			PH_DWELL: begin
				tick_d = tick_inc;
				if (tick_inc >= HOLD_W'(dwell_ticks)) begin
					tick_d  = '0;
					phase_d = PH_SCANNING;
				end
			end
			default: begin
				phase_d = PH_SCANNING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			next_row_q   <= '0;
			active_row_q <= '0;
			phase_q      <= PH_SCANNING;
			tick_q       <= '0;
		end else if (step) begin
			column_q     <= column_d;
			next_row_q   <= next_row_d;
			active_row_q <= active_row_d;
			phase_q      <= phase_d;
			tick_q       <= tick_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/keypad_scan_push_hold.sv -----
// Matrix keypad scanner with push and hold detection.
// Usage: each word on the keys channel is one scan tick carrying the sampled
// row lines; for every accepted word exactly one word leaves on the events
// channel, giving the column that was driven during that tick and, when a key
// event completes, its kind (push or hold) and its button code.
// A word accepted at a clock edge sits in the input register, is processed by
// the scan state machine and its result is presented from the output register.
// Throughput is one word per cycle unless the receiver stalls; the state
// update is a single pass of counter, compare and priority logic between
// the two registers.
// The configuration port writes the hold time and the column dwell time; it
// is meant to be used while no words are in flight.
// At reset both registers empty, the hold time is 1500 ticks, the dwell time
// is 30 ticks and scanning starts at the first column.
// When the receiver stalls the output word is held, the input register fills
// and then keys.ready drops until the output word is taken.
// Depends on kps_pkg, kps_if and kps_scan.
`default_nettype none

module keypad_scan_push_hold #(
	parameter int unsigned COLUMNS = kps_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = kps_pkg::ROWS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write,
	input  wire logic                        cfg_index,
	input  wire logic [kps_pkg::CFG_W-1:0]   cfg_data,
	kps_row_if.sink                          keys,
	kps_event_if.source                      events
);
	import kps_pkg::*;

	logic [HOLD_W-1:0]  hold_q;
	logic [DWELL_W-1:0] dwell_q;
	logic               valid_s1;
	logic [ROW_W-1:0]   rows_s1;
	logic               valid_s2;
	result_t            result_s2;
	result_t            result;
	logic               advance;
	logic               step;

	assign advance    = !valid_s2 || events.ready;
	assign step       = valid_s1 && advance;
	assign keys.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= HOLD_RESET;
			dwell_q <= DWELL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HOLD:  hold_q  <= cfg_data[HOLD_W-1:0];
				CFG_DWELL: dwell_q <= cfg_data[DWELL_W-1:0];
				default:   hold_q  <= hold_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (keys.ready) begin
				valid_s1 <= keys.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			rows_s1 <= keys.row_lines;
		end
		if (step) begin
			result_s2 <= result;
		end
	end

	kps_scan #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rows        (rows_s1),
		.hold_ticks  (hold_q),
		.dwell_ticks (dwell_q),
		.result      (result)
	);

	assign events.valid        = valid_s2;
	assign events.column_drive = result_s2.column_drive;
	assign events.event_valid  = result_s2.event_valid;
	assign events.event_kind   = result_s2.event_kind;
	assign events.button_code  = result_s2.button_code;

endmodule

`default_nettype wire
